// ----- src/dowq_pkg.sv -----
package dowq_pkg;

  localparam int SLOTS = 16;
  localparam int SLOT_W = 4;
  localparam int TIME_BITS = 32;
  localparam int TAG_BITS = 32;
  localparam int SLOP_BITS = 8;
  localparam logic [SLOP_BITS-1:0] SLOP_RESET = 8'd2;

  // operation codes
  localparam logic [2:0] OP_ENTER = 3'd0;
  localparam logic [2:0] OP_DELETE = 3'd1;
  localparam logic [2:0] OP_GET = 3'd2;
  localparam logic [2:0] OP_PUT = 3'd3;
  localparam logic [2:0] OP_RESET = 3'd4;

  // status codes
  localparam logic [2:0] STS_OK = 3'd0;
  localparam logic [2:0] STS_EMPTY = 3'd1;
  localparam logic [2:0] STS_NOT_DUE = 3'd2;
  localparam logic [2:0] STS_FULL = 3'd3;
  localparam logic [2:0] STS_BAD = 3'd4;

  typedef enum logic [1:0] {
    CH_NONE,
    CH_INS,
    CH_REM
  } chain_op_t;

  typedef struct packed {
    chain_op_t code;
    logic [SLOT_W-1:0] slot;
    logic [TIME_BITS-1:0] deadline;
  } chain_cmd_t;

  typedef struct packed {
    logic valid;
    logic [SLOT_W-1:0] slot;
    logic [TIME_BITS-1:0] deadline;
  } cell_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_REINS
  } state_t;

endpackage

// ----- src/deadline_ordered_work_queue_top.sv -----
// channel | handshake             | payload
// in      | in_valid / in_stall   | operation, item_tag, item_deadline, handle, now_time
// out     | out_valid / out_stall | status, slot_out, tag_out, wake_deadline
// cfg     | cfg_valid / cfg_ready | deadline_slop
// an item is accepted in S_IDLE, then the cell chain is updated in S_EXEC;
// an earlier deadline reset on a queued item also passes S_REINS (remove, re-insert)
// the update cycle waits while a finished result is still held by out_stall
// reset clears the chain, slot flags and the slop register (to 2)
// in_stall is high whenever an item is in work
module deadline_ordered_work_queue_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_item_tag,
  input  logic [31:0] in_item_deadline,
  input  logic [3:0]  in_handle,
  input  logic [31:0] in_now_time,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_status,
  output logic [3:0]  out_slot_out,
  output logic [31:0] out_tag_out,
  output logic [31:0] out_wake_deadline,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [7:0]  cfg_deadline_slop
);

  localparam int N = dowq_pkg::SLOTS;
  localparam int W = dowq_pkg::SLOT_W;
  localparam int TB = dowq_pkg::TIME_BITS;

  dowq_pkg::state_t state_r, state_nxt;
  logic [7:0] slop_r;

  // latched item
  logic [2:0] op_r;
  logic [31:0] tag_r;
  logic [TB-1:0] dl_r;
  logic [3:0] h_r;
  logic [TB-1:0] now_r;

  // slot pool
  logic [TB-1:0] sdl_r [N];
  logic [31:0] stag_r [N];
  logic [N-1:0] alloc_r, inuse_r, rpend_r, dpend_r;
  logic [N-1:0] alloc_nxt, inuse_nxt, rpend_nxt, dpend_nxt;
  logic sdl_we, stag_we;
  logic [W-1:0] sdl_wa;
  logic [TB-1:0] sdl_wd;

  // output register
  logic out_valid_r;
  logic [2:0] status_r, status_nxt;
  logic [3:0] slot_out_r, slot_out_nxt;
  logic [31:0] tag_out_r, tag_out_nxt;
  logic [31:0] wake_r, wake_nxt;
  logic out_load;

  // chain
  dowq_pkg::chain_cmd_t cmd;
  dowq_pkg::cell_t cells [N];
  logic [N-1:0] keeps, passes;

  // reinsertion held across cycles
  logic [TB-1:0] rdl_r, rdl_nxt;

  // helpers
  logic [W-1:0] s;
  logic hvalid;
  logic [W-1:0] free_idx;
  logic free_found;
  logic [W-1:0] hd;
  logic [TB-1:0] hdl, thr;
  logic [TB-1:0] put_dl;
  logic go;

  assign s = h_r[W-1:0];
  assign hvalid = (32'(h_r) < 32'(N)) && alloc_r[s];
  assign hd = cells[0].slot;
  assign hdl = cells[0].deadline;
  assign thr = (hdl > TB'(slop_r)) ? hdl - TB'(slop_r) : '0;
  assign put_dl = (!rpend_r[s] || sdl_r[s] > dl_r) ? dl_r : sdl_r[s];
  assign go = !out_valid_r || !out_stall;

  // lowest free slot
  always_comb begin
    free_idx = '0;
    free_found = 1'b0;
    for (int i = N - 1; i >= 0; i--) begin
      if (!alloc_r[i]) begin
        free_idx = W'(i);
        free_found = 1'b1;
      end
    end
  end

  // sequencer and operation decode
  always_comb begin
    state_nxt = state_r;
    alloc_nxt = alloc_r;
    inuse_nxt = inuse_r;
    rpend_nxt = rpend_r;
    dpend_nxt = dpend_r;
    sdl_we = 1'b0;
    sdl_wa = s;
    sdl_wd = dl_r;
    stag_we = 1'b0;
    cmd.code = dowq_pkg::CH_NONE;
    cmd.slot = s;
    cmd.deadline = dl_r;
    status_nxt = dowq_pkg::STS_OK;
    slot_out_nxt = '0;
    tag_out_nxt = '0;
    wake_nxt = '0;
    out_load = 1'b0;
    rdl_nxt = rdl_r;
    case (state_r)
      dowq_pkg::S_IDLE: begin
        if (in_valid) begin
          state_nxt = dowq_pkg::S_EXEC;
        end
      end
      dowq_pkg::S_EXEC: begin
        if (go) begin
          out_load = 1'b1;
          state_nxt = dowq_pkg::S_IDLE;
          case (op_r)
            dowq_pkg::OP_ENTER: begin
              if (!free_found) begin
                status_nxt = dowq_pkg::STS_FULL;
              end else begin
                alloc_nxt[free_idx] = 1'b1;
                inuse_nxt[free_idx] = 1'b0;
                rpend_nxt[free_idx] = 1'b0;
                dpend_nxt[free_idx] = 1'b0;
                sdl_we = 1'b1;
                sdl_wa = free_idx;
                stag_we = 1'b1;
                cmd.code = dowq_pkg::CH_INS;
                cmd.slot = free_idx;
                slot_out_nxt = 4'(free_idx);
              end
            end
            dowq_pkg::OP_DELETE: begin
              if (!hvalid) begin
                status_nxt = dowq_pkg::STS_BAD;
              end else if (inuse_r[s]) begin
                dpend_nxt[s] = 1'b1;
              end else begin
                cmd.code = dowq_pkg::CH_REM;
                alloc_nxt[s] = 1'b0;
                rpend_nxt[s] = 1'b0;
                dpend_nxt[s] = 1'b0;
              end
            end
            dowq_pkg::OP_GET: begin
              if (!cells[0].valid) begin
                status_nxt = dowq_pkg::STS_EMPTY;
              end else if (now_r < thr) begin
                status_nxt = dowq_pkg::STS_NOT_DUE;
                wake_nxt = 32'(hdl);
              end else begin
                cmd.code = dowq_pkg::CH_REM;
                cmd.slot = hd;
                inuse_nxt[hd] = 1'b1;
                rpend_nxt[hd] = 1'b0;
                dpend_nxt[hd] = 1'b0;
                slot_out_nxt = 4'(hd);
                tag_out_nxt = stag_r[hd];
              end
            end
            dowq_pkg::OP_PUT: begin
              if (!hvalid || !inuse_r[s]) begin
                status_nxt = dowq_pkg::STS_BAD;
              end else if (dpend_r[s]) begin
                alloc_nxt[s] = 1'b0;
                inuse_nxt[s] = 1'b0;
                rpend_nxt[s] = 1'b0;
                dpend_nxt[s] = 1'b0;
              end else begin
                sdl_we = 1'b1;
                sdl_wd = put_dl;
                inuse_nxt[s] = 1'b0;
                rpend_nxt[s] = 1'b0;
                cmd.code = dowq_pkg::CH_INS;
                cmd.deadline = put_dl;
              end
            end
            dowq_pkg::OP_RESET: begin
              if (!hvalid || dpend_r[s]) begin
                status_nxt = dowq_pkg::STS_BAD;
              end else if (inuse_r[s]) begin
                sdl_we = 1'b1;
                sdl_wd = put_dl;
                rpend_nxt[s] = 1'b1;
              end else if (dl_r < sdl_r[s]) begin
                // pull out now, put back with the earlier deadline next cycle
                cmd.code = dowq_pkg::CH_REM;
                sdl_we = 1'b1;
                rdl_nxt = dl_r;
                state_nxt = dowq_pkg::S_REINS;
              end
            end
            default: status_nxt = dowq_pkg::STS_BAD;
          endcase
        end
      end
      dowq_pkg::S_REINS: begin
        cmd.code = dowq_pkg::CH_INS;
        cmd.deadline = rdl_r;
        state_nxt = dowq_pkg::S_IDLE;
      end
      default: state_nxt = dowq_pkg::S_IDLE;
    endcase
  end

  // cell chain
  for (genvar g = 0; g < N; g++) begin : g_cell
    dowq_pkg::cell_t left_d, right_d;
    logic left_keep, left_passed;
    if (g == 0) begin : g_first
      assign left_d = cells[0];
      assign left_keep = 1'b1;
      assign left_passed = 1'b0;
    end else begin : g_mid
      assign left_d = cells[g-1];
      assign left_keep = keeps[g-1];
      assign left_passed = passes[g-1];
    end
    if (g == N - 1) begin : g_last
      assign right_d = '0;
    end else begin : g_inner
      assign right_d = cells[g+1];
    end
    dowq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .cmd        (cmd),
      .left_d     (left_d),
      .right_d    (right_d),
      .left_keep  (left_keep),
      .left_passed(left_passed),
      .cur        (cells[g]),
      .keep       (keeps[g]),
      .passed     (passes[g])
    );
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= dowq_pkg::S_IDLE;
      slop_r <= dowq_pkg::SLOP_RESET;
      alloc_r <= '0;
      inuse_r <= '0;
      rpend_r <= '0;
      dpend_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      alloc_r <= alloc_nxt;
      inuse_r <= inuse_nxt;
      rpend_r <= rpend_nxt;
      dpend_r <= dpend_nxt;
      if (cfg_valid) begin
        slop_r <= cfg_deadline_slop;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (state_r == dowq_pkg::S_IDLE && in_valid) begin
      op_r <= in_operation;
      tag_r <= in_item_tag;
      dl_r <= in_item_deadline;
      h_r <= in_handle;
      now_r <= in_now_time;
    end
    if (sdl_we) begin
      sdl_r[sdl_wa] <= sdl_wd;
    end
    if (stag_we) begin
      stag_r[free_idx] <= tag_r;
    end
    rdl_r <= rdl_nxt;
    if (out_load) begin
      status_r <= status_nxt;
      slot_out_r <= slot_out_nxt;
      tag_out_r <= tag_out_nxt;
      wake_r <= wake_nxt;
    end
  end

  assign in_stall = (state_r != dowq_pkg::S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_status = status_r;
  assign out_slot_out = slot_out_r;
  assign out_tag_out = tag_out_r;
  assign out_wake_deadline = wake_r;

`ifndef NO_ASSERTIONS
  // chain stays packed at the head
  a_packed: assert property (@(posedge clk) disable iff (!rst_n)
    !cells[0].valid |-> !cells[1].valid)
    else $error("queue chain has a gap at the head");

  // chain stays sorted at the head
  a_sorted: assert property (@(posedge clk) disable iff (!rst_n)
    cells[1].valid |-> !(cells[1].deadline < cells[0].deadline))
    else $error("queue head out of deadline order");

  // a queued head is allocated and not in use
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    cells[0].valid |-> (alloc_r[cells[0].slot] && !inuse_r[cells[0].slot]))
    else $error("queue head names a bad slot");

  // a new result only comes from the update cycle
  a_res: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == dowq_pkg::S_EXEC))
    else $error("result beat without an update cycle");
`endif

endmodule

// ----- src/dowq_cell.sv -----
module dowq_cell (
  input  logic                clk,
  input  logic                rst_n,
  input  dowq_pkg::chain_cmd_t cmd,
  input  dowq_pkg::cell_t     left_d,
  input  dowq_pkg::cell_t     right_d,
  input  logic                left_keep,
  input  logic                left_passed,
  output dowq_pkg::cell_t     cur,
  output logic                keep,
  output logic                passed
);

  dowq_pkg::cell_t cur_r;
  dowq_pkg::cell_t cur_nxt;

  // entry stays in place on insert when it is not later than the new one
  assign keep = cur_r.valid && !(cmd.deadline < cur_r.deadline);
  // the removed entry is here or somewhere to the left
  assign passed = left_passed || (cur_r.valid && cur_r.slot == cmd.slot);
  assign cur = cur_r;

  // shift right on insert, left on remove
  always_comb begin
    cur_nxt = cur_r;
    case (cmd.code)
      dowq_pkg::CH_INS: begin
        if (!keep) begin
          if (left_keep) begin
            cur_nxt.valid = 1'b1;
            cur_nxt.slot = cmd.slot;
            cur_nxt.deadline = cmd.deadline;
          end else begin
            cur_nxt = left_d;
          end
        end
      end
      dowq_pkg::CH_REM: begin
        if (passed) begin
          cur_nxt = right_d;
        end
      end
      default: cur_nxt = cur_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r.valid <= 1'b0;
    end else begin
      cur_r <= cur_nxt;
    end
  end

endmodule

// ----- bench/deadline_ordered_work_queue_checker.sv -----
`timescale 1ns / 1ps

module deadline_ordered_work_queue_checker
  import dowq_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [2:0]  in_operation,
  input  logic [31:0] in_item_tag,
  input  logic [31:0] in_item_deadline,
  input  logic [3:0]  in_handle,
  input  logic [31:0] in_now_time,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  out_status,
  input  logic [3:0]  out_slot_out,
  input  logic [31:0] out_tag_out,
  input  logic [31:0] out_wake_deadline,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [7:0]  cfg_deadline_slop,
  output int          mismatch_count,
  output int          results_owed
);

  typedef struct {
    logic [2:0]  status;
    logic [3:0]  slot;
    logic [31:0] tag;
    logic [31:0] wake;
  } queue_reply_t;

  // shadow of the slot pool and the deadline order
  logic [TIME_BITS-1:0] slot_dl [SLOTS];
  logic [TAG_BITS-1:0]  slot_tg [SLOTS];
  bit                   taken [SLOTS];
  bit                   popped [SLOTS];
  bit                   reset_due [SLOTS];
  bit                   delete_due [SLOTS];
  logic [SLOT_W-1:0]    by_deadline [$];
  logic [SLOP_BITS-1:0] slop;
  queue_reply_t         replies_owed [$];

  function automatic void order_insert(int s);
    int pos;
    pos = 0;
    while (pos < by_deadline.size() && !(slot_dl[s] < slot_dl[by_deadline[pos]])) pos++;
    by_deadline.insert(pos, s[SLOT_W-1:0]);
  endfunction

  function automatic void order_remove(int s);
    for (int i = 0; i < by_deadline.size(); i++) begin
      if (by_deadline[i] == s) begin
        by_deadline.delete(i);
        return;
      end
    end
  endfunction

  function automatic void release_slot(int s);
    taken[s] = 0;
    popped[s] = 0;
    reset_due[s] = 0;
    delete_due[s] = 0;
  endfunction

  // work out the reply to one operation and update the shadow
  function automatic queue_reply_t queue_apply(logic [2:0] op, logic [31:0] tg,
                                               logic [31:0] dl, logic [3:0] h,
                                               logic [31:0] now);
    queue_reply_t r;
    int s;
    int free_idx;
    logic [31:0] thr;
    bit ok;
    r = '{STS_OK, '0, '0, '0};
    s = h;
    ok = taken[s];
    case (op)
      OP_ENTER: begin
        free_idx = -1;
        for (int i = SLOTS - 1; i >= 0; i--) if (!taken[i]) free_idx = i;
        if (free_idx < 0) begin
          r.status = STS_FULL;
        end else begin
          release_slot(free_idx);
          taken[free_idx] = 1;
          slot_tg[free_idx] = tg;
          slot_dl[free_idx] = dl;
          order_insert(free_idx);
          r.slot = free_idx[3:0];
        end
      end
      OP_DELETE: begin
        if (!ok) r.status = STS_BAD;
        else if (popped[s]) delete_due[s] = 1;
        else begin
          order_remove(s);
          release_slot(s);
        end
      end
      OP_GET: begin
        if (by_deadline.size() == 0) begin
          r.status = STS_EMPTY;
        end else begin
          s = by_deadline[0];
          thr = (slot_dl[s] > slop) ? slot_dl[s] - slop : '0;
          if (now < thr) begin
            r.status = STS_NOT_DUE;
            r.wake = slot_dl[s];
          end else begin
            void'(by_deadline.pop_front());
            popped[s] = 1;
            reset_due[s] = 0;
            delete_due[s] = 0;
            r.slot = s[3:0];
            r.tag = slot_tg[s];
          end
        end
      end
      OP_PUT: begin
        if (!ok || !popped[s]) r.status = STS_BAD;
        else if (delete_due[s]) release_slot(s);
        else begin
          if (!reset_due[s] || slot_dl[s] > dl) slot_dl[s] = dl;
          popped[s] = 0;
          reset_due[s] = 0;
          order_insert(s);
        end
      end
      OP_RESET: begin
        if (!ok || delete_due[s]) r.status = STS_BAD;
        else if (popped[s]) begin
          if (!reset_due[s] || slot_dl[s] > dl) slot_dl[s] = dl;
          reset_due[s] = 1;
        end else if (dl < slot_dl[s]) begin
          order_remove(s);
          slot_dl[s] = dl;
          order_insert(s);
        end
      end
      default: r.status = STS_BAD;
    endcase
    return r;
  endfunction

  // watch the three channels on each rising edge
  always @(posedge clk) begin
    queue_reply_t want;
    if (!rst_n) begin
      for (int i = 0; i < SLOTS; i++) release_slot(i);
      by_deadline.delete();
      replies_owed.delete();
      slop = SLOP_RESET;
      mismatch_count = 0;
    end else begin
      if (cfg_valid && cfg_ready) slop = cfg_deadline_slop;
      if (in_valid && !in_stall)
        replies_owed.push_back(queue_apply(in_operation, in_item_tag, in_item_deadline,
                                           in_handle, in_now_time));
      if (out_valid && !out_stall) begin
        if (replies_owed.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10) $display("unexpected result beat at %0t", $realtime);
        end else begin
          want = replies_owed.pop_front();
          if (out_status !== want.status || out_slot_out !== want.slot ||
              out_tag_out !== want.tag || out_wake_deadline !== want.wake) begin
            mismatch_count++;
            if (mismatch_count <= 10)
              $display("result mismatch at %0t: exp sts %0d slot %0d tag %h wake %h, got sts %0d slot %0d tag %h wake %h",
                       $realtime, want.status, want.slot, want.tag, want.wake,
                       out_status, out_slot_out, out_tag_out, out_wake_deadline);
          end
        end
      end
    end
    results_owed = replies_owed.size();
  end

endmodule

// ----- bench/tb_deadline_ordered_work_queue_top.sv -----
`timescale 1ns / 1ps

module tb_deadline_ordered_work_queue_top;
  import dowq_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [2:0]  in_operation = OP_GET;
  logic [31:0] in_item_tag = '0;
  logic [31:0] in_item_deadline = '0;
  logic [3:0]  in_handle = '0;
  logic [31:0] in_now_time = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [2:0]  out_status;
  logic [3:0]  out_slot_out;
  logic [31:0] out_tag_out;
  logic [31:0] out_wake_deadline;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [7:0]  cfg_deadline_slop = '0;

  int  mismatch_count;
  int  results_owed;
  bit  hold_request = 0;
  bit  send_quiet = 0;
  logic [31:0] tick_base = 1000;

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  deadline_ordered_work_queue_top dut (.*);

  deadline_ordered_work_queue_checker checker_i (.*);

  // receiver: random stall per beat, quiet stretches, one long hold-off
  initial begin
    int n;
    bit quiet;
    quiet = 0;
    forever begin
      if ($urandom_range(0, 15) == 0) quiet = !quiet;
      if (hold_request) begin
        n = 300;
        hold_request = 0;
      end else begin
        n = quiet ? 0 : $urandom_range(0, 17);
      end
      if (n > 0) begin
        out_stall <= 1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!(out_valid && !out_stall));
    end
  end

  task automatic send_op(logic [2:0] op, logic [31:0] tg, logic [31:0] dl,
                         logic [3:0] h, logic [31:0] now);
    int gap;
    if ($urandom_range(0, 15) == 0) send_quiet = !send_quiet;
    gap = send_quiet ? 0 : $urandom_range(0, 17);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    in_operation <= op;
    in_item_tag <= tg;
    in_item_deadline <= dl;
    in_handle <= h;
    in_now_time <= now;
    do @(posedge clk); while (in_stall);
  endtask

  // drain, let the block settle, then write the slop register
  task automatic set_slop(logic [7:0] v);
    in_valid <= 0;
    do @(negedge clk); while (results_owed != 0);
    repeat (4) @(posedge clk);
    cfg_valid <= 1;
    cfg_deadline_slop <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [31:0] pick_deadline();
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return 32'hffff_ffff - $urandom_range(0, 3);
      2: return $urandom_range(0, 3);
      default: return tick_base + $urandom_range(0, 60);
    endcase
  endfunction

  task automatic random_op();
    int r;
    logic [31:0] now;
    r = $urandom_range(0, 99);
    now = ($urandom_range(0, 19) == 0) ? $urandom() : tick_base + $urandom_range(0, 60);
    tick_base = tick_base + $urandom_range(0, 3);
    if (r < 26) send_op(OP_ENTER, $urandom(), pick_deadline(), 4'($urandom()), $urandom());
    else if (r < 52) send_op(OP_GET, $urandom(), $urandom(), 4'($urandom()), now);
    else if (r < 70)
      send_op(OP_PUT, $urandom(), pick_deadline(), 4'($urandom_range(0, 15)), now);
    else if (r < 80)
      send_op(OP_DELETE, $urandom(), $urandom(), 4'($urandom_range(0, 15)), now);
    else if (r < 96)
      send_op(OP_RESET, $urandom(), pick_deadline(), 4'($urandom_range(0, 15)), now);
    else send_op(3'($urandom_range(5, 7)), $urandom(), $urandom(), 4'($urandom()), now);
  endtask

  // stimulus and verdict
  initial begin
    logic [7:0] slops [6];
    slops = '{8'd0, 8'd255, 8'd1, 8'd0, 8'd255, 8'd2};
    slops[3] = 8'($urandom());
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed corners with the reset slop of two
    send_op(OP_GET, '0, '0, '0, '0);
    send_op(OP_ENTER, 32'hffff_ffff, 32'hffff_ffff, 4'hf, 32'hffff_ffff);
    send_op(OP_ENTER, '0, '0, '0, '0);
    send_op(OP_ENTER, 32'h1234, 32'd1, '0, '0);
    send_op(OP_GET, '0, '0, '0, 32'd0);
    send_op(OP_GET, '0, '0, '0, 32'd0);
    send_op(OP_GET, '0, '0, '0, 32'd100);
    send_op(OP_RESET, '0, 32'd50, 4'd0, '0);
    send_op(OP_RESET, '0, 32'd60, 4'd0, '0);
    send_op(OP_GET, '0, '0, '0, 32'd48);
    send_op(OP_RESET, '0, 32'd10, 4'd0, '0);
    send_op(OP_RESET, '0, 32'd20, 4'd0, '0);
    send_op(OP_PUT, '0, 32'd30, 4'd0, '0);
    send_op(OP_DELETE, '0, '0, 4'd1, '0);
    send_op(OP_RESET, '0, 32'd5, 4'd1, '0);
    send_op(OP_PUT, '0, 32'd5, 4'd1, '0);
    send_op(OP_PUT, '0, 32'd5, 4'd1, '0);
    send_op(OP_PUT, '0, 32'd5, 4'd2, '0);
    send_op(OP_DELETE, '0, '0, 4'd2, '0);
    send_op(OP_DELETE, '0, '0, 4'd15, '0);
    send_op(3'd5, '0, '0, '0, '0);
    send_op(3'd7, 32'hffff_ffff, 32'hffff_ffff, 4'hf, 32'hffff_ffff);
    send_op(OP_GET, '0, '0, '0, 32'hffff_ffff);

    // random phases, each under its own slop
    for (int p = 0; p < 6; p++) begin
      set_slop(slops[p]);
      if (p == 1) hold_request = 1;
      // fill the pool once, in the third phase, so that enter reports full
      if (p == 2) repeat (18) send_op(OP_ENTER, $urandom(), pick_deadline(), '0, '0);
      for (int i = 0; i < 115; i++) random_op();
    end

    in_valid <= 0;
    do @(negedge clk); while (results_owed != 0);
    repeat (10) @(posedge clk);
    if (mismatch_count == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

  initial begin
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule

// ----- sim.f -----
src/dowq_pkg.sv
src/dowq_cell.sv
src/deadline_ordered_work_queue_top.sv
bench/deadline_ordered_work_queue_checker.sv
bench/tb_deadline_ordered_work_queue_top.sv
